FILE: hdl/gb2312_font_rom_address_parser_defines.svh
// Assertion macros shared by the font ROM address parser RTL.
`ifndef GB2312_FONT_ROM_ADDRESS_PARSER_DEFINES_SVH
`define GB2312_FONT_ROM_ADDRESS_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

FILE: hdl/gbfr_pkg.sv
// Types and constants of the GB2312 font ROM address parser.
`default_nettype none
package gbfr_pkg;

    localparam int ADDR_W        = 18;
    localparam int MAX_BYTES_DEF = 16;

    localparam logic [7:0] HANZI_LO  = 8'hB0;
    localparam logic [7:0] HANZI_HI  = 8'hF7;
    localparam logic [7:0] SYM_LO    = 8'hA1;
    localparam logic [7:0] SYM_HI    = 8'hA9;
    localparam logic [7:0] TRAIL_MIN = 8'hA1;
    localparam logic [7:0] ASCII_LO  = 8'h20;
    localparam logic [7:0] ASCII_HI  = 8'h7E;

    localparam int ROW_LEN      = 94;
    localparam int HANZI_OFS    = 846;
    localparam int WIDE_SHIFT   = 5;       // 32 bytes per 16x16 glyph
    localparam int NARROW_SHIFT = 4;       // 16 bytes per 8x16 glyph
    localparam int NARROW_BASE  = 'h3B7C0;

    localparam int STEP_WIDE   = 16;
    localparam int STEP_NARROW = 8;

    typedef enum logic {
        KIND_WIDE   = 1'b0,
        KIND_NARROW = 1'b1
    } glyph_kind_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       first_of_string;
        logic [7:0] start_page;
        logic [7:0] start_column;
        logic       reverse_video;
    } in_item_t;

    typedef struct packed {
        logic              glyph_valid;
        logic [ADDR_W-1:0] font_address;
        glyph_kind_t       glyph_kind;
        logic [7:0]        glyph_page;
        logic [7:0]        glyph_column;
        logic              glyph_reverse;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/gbfr_addr.sv
// Font ROM address arithmetic for double-byte and ASCII glyphs.
`default_nettype none
module gbfr_addr (
    input  wire logic [7:0]                 lead_byte,
    input  wire logic [7:0]                 code_byte,
    output logic      [gbfr_pkg::ADDR_W-1:0] wide_addr,
    output logic      [gbfr_pkg::ADDR_W-1:0] narrow_addr
);

    localparam int IDX_W = gbfr_pkg::ADDR_W - gbfr_pkg::WIDE_SHIFT;

    logic       is_hanzi;
    logic [7:0] row_diff;
    logic [7:0] trail_diff;
    logic [7:0] char_diff;
    logic [IDX_W-1:0] row_term;
    logic [IDX_W-1:0] glyph_idx;

    always_comb begin
        is_hanzi   = (lead_byte >= gbfr_pkg::HANZI_LO);
        row_diff   = is_hanzi ? (lead_byte - gbfr_pkg::HANZI_LO)
                              : (lead_byte - gbfr_pkg::SYM_LO);
        trail_diff = code_byte - gbfr_pkg::TRAIL_MIN;
        row_term   = IDX_W'(row_diff[6:0]) * IDX_W'(gbfr_pkg::ROW_LEN);
        glyph_idx  = row_term + IDX_W'(trail_diff[6:0])
                   + (is_hanzi ? IDX_W'(gbfr_pkg::HANZI_OFS) : '0);
        wide_addr  = {glyph_idx, {gbfr_pkg::WIDE_SHIFT{1'b0}}};

        char_diff   = code_byte - gbfr_pkg::ASCII_LO;
        narrow_addr = gbfr_pkg::ADDR_W'(gbfr_pkg::NARROW_BASE)
                    + gbfr_pkg::ADDR_W'({char_diff[6:0], {gbfr_pkg::NARROW_SHIFT{1'b0}}});
    end

endmodule
`default_nettype wire

FILE: hdl/gbfr_core.sv
// String state of the parser and the per-byte glyph decision.
`default_nettype none
module gbfr_core #(
    parameter int MAX_BYTES = gbfr_pkg::MAX_BYTES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire gbfr_pkg::in_item_t item,
    output gbfr_pkg::result_t       result
);

    // Positions run up to MAX_BYTES + 1 when a lead sits at the last slot.
    localparam int POS_W = $clog2(MAX_BYTES + 2);

    logic [7:0]       held_lead_reg, held_lead_next;
    logic             holding_reg, holding_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       column_reg, column_next;
    logic [7:0]       page_reg, page_next;
    logic             reverse_reg, reverse_next;
    logic             ended_reg, ended_next;

    logic [gbfr_pkg::ADDR_W-1:0] wide_addr;
    logic [gbfr_pkg::ADDR_W-1:0] narrow_addr;
    logic                        fresh;
    logic [7:0]                  b;

    gbfr_addr u_addr (
        .lead_byte   (held_lead_reg),
        .code_byte   (item.code_byte),
        .wide_addr   (wide_addr),
        .narrow_addr (narrow_addr)
    );

    always_comb begin
        b              = item.code_byte;
        held_lead_next = held_lead_reg;
        holding_next   = holding_reg;
        pos_next       = pos_reg;
        column_next    = column_reg;
        page_next      = page_reg;
        reverse_next   = reverse_reg;
        ended_next     = ended_reg;
        result         = '0;
        fresh          = 1'b0;

        if (item.first_of_string) begin
            page_next    = item.start_page;
            column_next  = item.start_column;
            reverse_next = item.reverse_video;
            holding_next = 1'b0;
            pos_next     = '0;
            ended_next   = 1'b0;
        end

        if (!ended_next) begin
            fresh = 1'b1;
            if (holding_next) begin
                holding_next = 1'b0;
                if (b >= gbfr_pkg::TRAIL_MIN) begin
                    result.glyph_valid   = 1'b1;
                    result.font_address  = wide_addr;
                    result.glyph_kind    = gbfr_pkg::KIND_WIDE;
                    result.glyph_page    = page_next;
                    result.glyph_column  = column_next;
                    result.glyph_reverse = reverse_next;
                    column_next = column_next + 8'(gbfr_pkg::STEP_WIDE);
                    pos_next    = pos_next + POS_W'(1);
                    fresh       = 1'b0;
                end
            end
        end

        // A byte that is not a trail byte is judged on its own.
        if (fresh) begin
            if (b == 8'h00 || pos_next >= POS_W'(MAX_BYTES)) begin
                ended_next = 1'b1;
            end else begin
                if ((b >= gbfr_pkg::HANZI_LO && b <= gbfr_pkg::HANZI_HI) ||
                    (b >= gbfr_pkg::SYM_LO && b <= gbfr_pkg::SYM_HI)) begin
                    held_lead_next = b;
                    holding_next   = 1'b1;
                end else if (b >= gbfr_pkg::ASCII_LO && b <= gbfr_pkg::ASCII_HI) begin
                    result.glyph_valid   = 1'b1;
                    result.font_address  = narrow_addr;
                    result.glyph_kind    = gbfr_pkg::KIND_NARROW;
                    result.glyph_page    = page_next;
                    result.glyph_column  = column_next;
                    result.glyph_reverse = reverse_next;
                    column_next = column_next + 8'(gbfr_pkg::STEP_NARROW);
                end
                pos_next = pos_next + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_lead_reg <= '0;
            holding_reg   <= 1'b0;
            pos_reg       <= '0;
            column_reg    <= '0;
            page_reg      <= '0;
            reverse_reg   <= 1'b0;
            ended_reg     <= 1'b1;
        end else if (advance) begin
            held_lead_reg <= held_lead_next;
            holding_reg   <= holding_next;
            pos_reg       <= pos_next;
            column_reg    <= column_next;
            page_reg      <= page_next;
            reverse_reg   <= reverse_next;
            ended_reg     <= ended_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/gb2312_font_rom_address_parser.sv
// Top level: GB2312 text byte stream to font ROM glyph addresses.
// A byte goes through the input register, then the result register that drives m_tdata.
// Throughput: one byte per cycle while m_tready keeps up; decode is combinational.
// Every accepted byte yields exactly one result transaction, glyph or not.
// Reset (aresetn low, synchronous) empties both registers and marks no string active.
`default_nettype none
`include "gb2312_font_rom_address_parser_defines.svh"
module gb2312_font_rom_address_parser #(
    parameter int MAX_BYTES = gbfr_pkg::MAX_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: code_byte[7:0], start_page[15:8], start_column[23:16],
    //          reverse_video[24], zero[31:25]
    input  wire logic [31:0] s_tdata,
    // s_tuser: first_of_string
    input  wire logic        s_tuser,
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: font_address[17:0], glyph_page[25:18], glyph_column[33:26],
    //          glyph_reverse[34], zero[39:35]
    output logic      [39:0] m_tdata,
    // m_tuser: glyph_valid[0], glyph_kind[1]
    output logic      [1:0]  m_tuser
);

    // The input register holds one byte; it drains into the result register
    // whenever that register is empty or its transaction completes, so a new
    // byte is taken in every cycle the result side keeps up.
    logic               in_valid_reg, in_valid_next;
    gbfr_pkg::in_item_t in_item_reg;
    logic               out_valid_reg, out_valid_next;
    gbfr_pkg::result_t  out_res_reg;
    gbfr_pkg::result_t  core_result;
    logic               advance;
    logic               s_fire;
    logic               m_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.code_byte       <= s_tdata[7:0];
            in_item_reg.first_of_string <= s_tuser;
            in_item_reg.start_page      <= s_tdata[15:8];
            in_item_reg.start_column    <= s_tdata[23:16];
            in_item_reg.reverse_video   <= s_tdata[24];
        end
        if (advance) begin
            out_res_reg <= core_result;
        end
    end

    // String state lives in the core and moves only when a byte is decoded.
    gbfr_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_res_reg.glyph_reverse,
                       out_res_reg.glyph_column,
                       out_res_reg.glyph_page,
                       out_res_reg.font_address};
    assign m_tuser  = {out_res_reg.glyph_kind, out_res_reg.glyph_valid};

    // A decoded byte always shows up as a result in the following cycle.
    `GBFR_ASSERT_NEXT(a_advance_shows, aclk, aresetn, advance, m_tvalid)
    // A taken byte never lands on an input register that is still full.
    `GBFR_ASSERT_NOW(a_no_overwrite, aclk, aresetn, in_valid_reg && s_tready, advance)
    // An ASCII kind is only reported together with a glyph.
    `GBFR_ASSERT_NOW(a_kind_needs_glyph, aclk, aresetn, m_tvalid && m_tuser[1], m_tuser[0])
    // A result without a glyph carries all-zero fields.
    `GBFR_ASSERT_NOW(a_empty_is_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 40'd0)

endmodule
`default_nettype wire
